### rtl/i2cm_pkg.sv
`timescale 1ns / 1ps

package i2cm_pkg;

  // Queue between the front and the back
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam int unsigned PhaseW = 5;
  localparam int unsigned DelayW = 16;

  // Command kinds
  localparam logic [1:0] KindStart = 2'd0;
  localparam logic [1:0] KindStop  = 2'd1;
  localparam logic [1:0] KindWrite = 2'd2;
  localparam logic [1:0] KindRead  = 2'd3;

  // Line operations of one sequence step
  localparam logic [2:0] OpSclLo   = 3'd0;
  localparam logic [2:0] OpSclHi   = 3'd1;
  localparam logic [2:0] OpSdaLo   = 3'd2;
  localparam logic [2:0] OpSdaHi   = 3'd3;
  localparam logic [2:0] OpSdaData = 3'd4;
  localparam logic [2:0] OpSdaAck  = 3'd5;
  localparam logic [2:0] OpSdaPost = 3'd6;

  localparam logic [7:0] MsbMask = 8'h80;

  typedef struct packed {
    logic       f_bit;  // shift in one data bit from SDA
    logic       f_ack;  // sample the slave ACK from SDA
    logic [2:0] op;
  } step_t;

  // Classified item as it travels through the queue
  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] kind;
    logic       last_read;
    logic [7:0] preload;  // shift register load: the byte for a write, zero otherwise
    logic       sda;
    logic       scl;
  } item_t;

  function automatic step_t step_lookup(input logic [1:0] kind, input logic [PhaseW-1:0] idx);
    step_t s;
    s = '{f_bit: 1'b0, f_ack: 1'b0, op: OpSclLo};
    case (kind)
      KindStart: begin
        case (idx)
          5'd1:    s.op = OpSdaHi;
          5'd2:    s.op = OpSclHi;
          5'd3:    s.op = OpSdaLo;
          default: s.op = OpSclLo;
        endcase
      end
      KindStop: begin
        case (idx)
          5'd1:    s.op = OpSdaLo;
          5'd2:    s.op = OpSclHi;
          5'd3:    s.op = OpSdaHi;
          default: s.op = OpSclLo;
        endcase
      end
      KindWrite: begin
        if (idx inside {5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22}) begin
          s.op = OpSdaData;
        end else if (idx inside {5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17, 5'd20, 5'd23}) begin
          s.op = OpSclHi;
        end else if (idx == 5'd25) begin
          s.op = OpSdaHi;
        end else if (idx == 5'd26) begin
          s.op    = OpSclHi;
          s.f_ack = 1'b1;
        end
      end
      default: begin
        if (idx == 5'd0) begin
          s.op = OpSdaHi;
        end else if (idx == 5'd2) begin
          s.op = OpSclHi;
        end else if (idx inside {5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd13, 5'd15, 5'd17}) begin
          s.f_bit = 1'b1;
        end else if (idx inside {5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd14, 5'd16, 5'd19}) begin
          s.op = OpSclHi;
        end else if (idx == 5'd18) begin
          s.op = OpSdaAck;
        end else if (idx == 5'd21) begin
          s.op = OpSdaPost;
        end
      end
    endcase
    return s;
  endfunction

  function automatic logic [PhaseW-1:0] step_len(input logic [1:0] kind);
    logic [PhaseW-1:0] len;
    case (kind)
      KindStart: len = 5'd5;
      KindStop:  len = 5'd4;
      KindWrite: len = 5'd28;
      default:   len = 5'd22;
    endcase
    return len;
  endfunction

endpackage

### rtl/i2cm_front.sv
`timescale 1ns / 1ps

module i2cm_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [15:0]          s_axis_tdata_i,   // tx_byte, sda_in, scl_in, zero pad
  input  logic [2:0]           s_axis_tuser_i,   // cmd_valid, kind
  input  logic                 s_axis_tlast_i,   // last_read
  output logic                 q_valid_o,
  output i2cm_pkg::item_t      q_item_o,
  input  logic                 q_pop_i
);

  i2cm_pkg::item_t                   mem_q [i2cm_pkg::FifoDepth];
  logic [i2cm_pkg::FifoPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [i2cm_pkg::FifoPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [i2cm_pkg::FifoCntW-1:0]     count_q, count_d;
  logic                              push;
  i2cm_pkg::item_t                   in_item;

  // Classify the incoming item
  always_comb begin
    in_item.cmd_valid = s_axis_tuser_i[0];
    in_item.kind      = s_axis_tuser_i[2:1];
    in_item.last_read = s_axis_tlast_i;
    in_item.preload   = (s_axis_tuser_i[2:1] == i2cm_pkg::KindWrite) ? s_axis_tdata_i[7:0]
                                                                     : 8'h00;
    in_item.sda       = s_axis_tdata_i[8];
    in_item.scl       = s_axis_tdata_i[9];
  end

  assign s_axis_tready_o = (count_q != i2cm_pkg::FifoCntW'(i2cm_pkg::FifoDepth));
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign q_valid_o       = (count_q != '0);
  assign q_item_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push    ? i2cm_pkg::FifoPtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = q_pop_i ? i2cm_pkg::FifoPtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = i2cm_pkg::FifoCntW'(count_q + i2cm_pkg::FifoCntW'(push)
                                   - i2cm_pkg::FifoCntW'(q_pop_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= i2cm_pkg::FifoCntW'(i2cm_pkg::FifoDepth))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> count_q != '0)
    else $error("pop from empty queue");

  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !q_pop_i |=> count_q != '0)
    else $error("pushed item lost");

endmodule

### rtl/i2cm_back.sv
`timescale 1ns / 1ps

module i2cm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 q_valid_i,
  input  i2cm_pkg::item_t      q_item_i,
  output logic                 q_pop_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [15:0]          m_axis_tdata_o,   // scl_out, sda_out, rx_byte, ack_received, pad
  output logic                 m_axis_tuser_o,   // ready_res
  output logic                 m_axis_tlast_o    // done_res
);

  logic [i2cm_pkg::DelayW-1:0] delay_q;
  logic [i2cm_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [7:0]                  shift_q, shift_d;
  logic [i2cm_pkg::DelayW-1:0] wait_q, wait_d;
  logic [1:0]                  kind_q, kind_d;
  logic                        nak_q, nak_d;
  logic                        scl_q, scl_d;
  logic                        sda_q, sda_d;
  logic                        ack_q, ack_d;
  logic [7:0]                  rx_q, rx_d;
  logic                        done;
  logic                        out_valid_q, out_valid_d;
  logic [15:0]                 out_data_q;
  logic                        out_ready_q, out_done_q;

  logic                        issue_en;
  logic [i2cm_pkg::PhaseW-1:0] issue_idx;
  logic [1:0]                  base_kind;
  logic [7:0]                  base_shift;
  logic                        base_nak;
  i2cm_pkg::step_t             cur_step, new_step;

  assign q_pop_o  = q_valid_i && (!out_valid_q || m_axis_tready_i);
  assign cur_step = i2cm_pkg::step_lookup(kind_q, i2cm_pkg::PhaseW'(phase_q - 1'b1));
  assign new_step = i2cm_pkg::step_lookup(base_kind, issue_idx);

  always_comb begin
    phase_d    = phase_q;
    shift_d    = shift_q;
    wait_d     = wait_q;
    kind_d     = kind_q;
    nak_d      = nak_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    ack_d      = ack_q;
    rx_d       = rx_q;
    done       = 1'b0;
    issue_en   = 1'b0;
    issue_idx  = phase_q;
    base_kind  = kind_q;
    base_shift = shift_q;
    base_nak   = nak_q;

    if (q_pop_o) begin
      if (phase_q == '0) begin
        if (q_item_i.cmd_valid) begin
          kind_d     = q_item_i.kind;
          nak_d      = q_item_i.last_read;
          issue_en   = 1'b1;
          issue_idx  = '0;
          base_kind  = q_item_i.kind;
          base_shift = q_item_i.preload;
          base_nak   = q_item_i.last_read;
        end
      end else if (wait_q != '0) begin
        wait_d = i2cm_pkg::DelayW'(wait_q - 1'b1);
      end else if (cur_step.op == i2cm_pkg::OpSclHi && !q_item_i.scl) begin
        // hold while the slave stretches the clock
      end else if (phase_q >= i2cm_pkg::step_len(kind_q)) begin
        phase_d = '0;
        done    = 1'b1;
        if (kind_q == i2cm_pkg::KindRead) begin
          rx_d = shift_q;
        end
      end else begin
        issue_en = 1'b1;
      end
    end

    if (issue_en) begin
      shift_d = base_shift;
      if (new_step.f_ack) begin
        ack_d = !q_item_i.sda;
      end
      if (new_step.f_bit) begin
        shift_d = {base_shift[6:0], q_item_i.sda};
      end
      case (new_step.op)
        i2cm_pkg::OpSclLo:   scl_d = 1'b0;
        i2cm_pkg::OpSclHi:   scl_d = 1'b1;
        i2cm_pkg::OpSdaLo:   sda_d = 1'b0;
        i2cm_pkg::OpSdaHi:   sda_d = 1'b1;
        i2cm_pkg::OpSdaData: begin
          sda_d   = |(base_shift & i2cm_pkg::MsbMask);
          shift_d = {base_shift[6:0], 1'b0};
        end
        i2cm_pkg::OpSdaAck:  sda_d = base_nak;
        default:             sda_d = !base_nak;
      endcase
      wait_d  = delay_q;
      phase_d = i2cm_pkg::PhaseW'(issue_idx + 1'b1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (q_pop_o) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q     <= 16'd250;
      phase_q     <= '0;
      shift_q     <= '0;
      wait_q      <= '0;
      kind_q      <= i2cm_pkg::KindStart;
      nak_q       <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      ack_q       <= 1'b0;
      rx_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        delay_q <= cfg_wdata_i;
      end
      phase_q     <= phase_d;
      shift_q     <= shift_d;
      wait_q      <= wait_d;
      kind_q      <= kind_d;
      nak_q       <= nak_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      ack_q       <= ack_d;
      rx_q        <= rx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load the result register with the state after this tick
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_data_q  <= {5'b0, ack_d, rx_d, sda_d, scl_d};
      out_ready_q <= (phase_d == '0);
      out_done_q  <= done;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_ready_q;
  assign m_axis_tlast_o  = out_done_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_done_q |-> out_ready_q)
    else $error("command finished but engine not idle");

  a_phase_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= i2cm_pkg::step_len(kind_q))
    else $error("phase beyond sequence length");

  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> m_axis_tvalid_o)
    else $error("consumed tick without result");

  a_idle_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && phase_q == '0 && !q_item_i.cmd_valid |=> phase_q == '0)
    else $error("engine left idle without command");

endmodule

### rtl/i2c_master_byte_engine_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Accept on                  Payload
// s_axis    in   tvalid & tready            tdata: tx_byte, sda_in, scl_in; tuser: cmd_valid,
//                                           kind; tlast: last_read
// m_axis    out  tvalid & tready            tdata: scl_out, sda_out, rx_byte, ack_received;
//                                           tuser: ready_res; tlast: done_res
// cfg       in   cfg_we_i                   cfg_wdata_i: delay_ticks
//
// One tick item per cycle unless the output stalls; each item is one sequencer tick.
// A four-entry queue sits between the front and the back; a result register follows.
// Reset leaves the lines released, the engine idle and delay_ticks at 250; no sweep.
// Output stall fills the result register, then the queue, then drops s_axis_tready_o.
// With no stall, an accepted item passes through its queue entry, then the result register.

module i2c_master_byte_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [7:0] tx_byte, [8] sda_in, [9] scl_in, rest zero
  input  logic [2:0]  s_axis_tuser_i,   // [0] cmd_valid, [2:1] kind
  input  logic        s_axis_tlast_i,   // last_read
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [0] scl_out, [1] sda_out, [9:2] rx_byte,
                                        // [10] ack_received, rest zero
  output logic        m_axis_tuser_o,   // ready_res
  output logic        m_axis_tlast_o,   // done_res
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic            q_valid;
  logic            q_pop;
  i2cm_pkg::item_t q_item;

  i2cm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .q_valid_o       (q_valid),
    .q_item_o        (q_item),
    .q_pop_i         (q_pop)
  );

  i2cm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

### test/i2c_master_byte_engine_unit_test.sv
`timescale 1ns / 1ps

module i2c_master_byte_engine_unit_test;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned IdlePhase  = 0;
  localparam int unsigned MaxSteps   = 28;
  localparam int unsigned ReportMax  = 10;

  typedef enum logic [1:0] {
    SdaLow,
    SdaHigh,
    SdaRand
  } sda_mode_e;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       last_read;
    logic       sda;
    logic       scl;
  } tick_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       ready;
    logic       done;
    logic [7:0] rx_byte;
    logic       ack;
  } line_res_t;

  // Tracks the line sequencer tick by tick and holds the line states it expects back.
  class line_scoreboard;
    logic [15:0]  delay_ticks;
    int unsigned  phase;
    logic [15:0]  wait_count;
    logic [7:0]   shift_reg;
    logic [7:0]   rx_hold;
    logic [1:0]   cmd_kind;
    logic         nak_pending;
    logic         scl_level;
    logic         sda_level;
    logic         ack_flag;
    logic [2:0]   seq_op [4][MaxSteps];
    bit           seq_shift [4][MaxSteps];
    bit           seq_ack [4][MaxSteps];
    int unsigned  seq_len [4];
    line_res_t    expected_lines [$];
    int unsigned  mismatch_count;

    function void push_step(logic [1:0] k, logic [2:0] op, bit shift_in = 1'b0,
                            bit ack_in = 1'b0);
      seq_op[k][seq_len[k]]    = op;
      seq_shift[k][seq_len[k]] = shift_in;
      seq_ack[k][seq_len[k]]   = ack_in;
      seq_len[k]++;
    endfunction

    function new();
      for (int k = 0; k < 4; k++) begin
        seq_len[k] = 0;
      end
      push_step(i2cm_pkg::KindStart, i2cm_pkg::OpSclLo);
      push_step(i2cm_pkg::KindStart, i2cm_pkg::OpSdaHi);
      push_step(i2cm_pkg::KindStart, i2cm_pkg::OpSclHi);
      push_step(i2cm_pkg::KindStart, i2cm_pkg::OpSdaLo);
      push_step(i2cm_pkg::KindStart, i2cm_pkg::OpSclLo);
      push_step(i2cm_pkg::KindStop, i2cm_pkg::OpSclLo);
      push_step(i2cm_pkg::KindStop, i2cm_pkg::OpSdaLo);
      push_step(i2cm_pkg::KindStop, i2cm_pkg::OpSclHi);
      push_step(i2cm_pkg::KindStop, i2cm_pkg::OpSdaHi);
      for (int b = 0; b < 8; b++) begin
        push_step(i2cm_pkg::KindWrite, i2cm_pkg::OpSclLo);
        push_step(i2cm_pkg::KindWrite, i2cm_pkg::OpSdaData);
        push_step(i2cm_pkg::KindWrite, i2cm_pkg::OpSclHi);
      end
      push_step(i2cm_pkg::KindWrite, i2cm_pkg::OpSclLo);
      push_step(i2cm_pkg::KindWrite, i2cm_pkg::OpSdaHi);
      push_step(i2cm_pkg::KindWrite, i2cm_pkg::OpSclHi, 1'b0, 1'b1);
      push_step(i2cm_pkg::KindWrite, i2cm_pkg::OpSclLo);
      push_step(i2cm_pkg::KindRead, i2cm_pkg::OpSdaHi);
      push_step(i2cm_pkg::KindRead, i2cm_pkg::OpSclLo);
      push_step(i2cm_pkg::KindRead, i2cm_pkg::OpSclHi);
      for (int b = 0; b < 7; b++) begin
        push_step(i2cm_pkg::KindRead, i2cm_pkg::OpSclLo, 1'b1);
        push_step(i2cm_pkg::KindRead, i2cm_pkg::OpSclHi);
      end
      push_step(i2cm_pkg::KindRead, i2cm_pkg::OpSclLo, 1'b1);
      push_step(i2cm_pkg::KindRead, i2cm_pkg::OpSdaAck);
      push_step(i2cm_pkg::KindRead, i2cm_pkg::OpSclHi);
      push_step(i2cm_pkg::KindRead, i2cm_pkg::OpSclLo);
      push_step(i2cm_pkg::KindRead, i2cm_pkg::OpSdaPost);
      delay_ticks    = 16'd250;
      phase          = IdlePhase;
      wait_count     = '0;
      shift_reg      = '0;
      rx_hold        = '0;
      cmd_kind       = i2cm_pkg::KindStart;
      nak_pending    = 1'b0;
      scl_level      = 1'b1;
      sda_level      = 1'b1;
      ack_flag       = 1'b0;
      mismatch_count = 0;
    endfunction

    function bit busy();
      return phase != IdlePhase;
    endfunction

    function int unsigned pending();
      return expected_lines.size();
    endfunction

    function void launch_step(int unsigned idx, logic sda);
      logic [2:0] op;
      op = seq_op[cmd_kind][idx];
      if (seq_ack[cmd_kind][idx]) begin
        ack_flag = ~sda;
      end
      if (seq_shift[cmd_kind][idx]) begin
        shift_reg = {shift_reg[6:0], sda};
      end
      case (op)
        i2cm_pkg::OpSclLo:   scl_level = 1'b0;
        i2cm_pkg::OpSclHi:   scl_level = 1'b1;
        i2cm_pkg::OpSdaLo:   sda_level = 1'b0;
        i2cm_pkg::OpSdaHi:   sda_level = 1'b1;
        i2cm_pkg::OpSdaData: begin
          sda_level = shift_reg[7];
          shift_reg = {shift_reg[6:0], 1'b0};
        end
        i2cm_pkg::OpSdaAck:  sda_level = nak_pending;
        default:             sda_level = ~nak_pending;
      endcase
      wait_count = delay_ticks;
      phase      = idx + 1;
    endfunction

    function void accept_tick(tick_t t);
      line_res_t   r;
      logic        finished;
      logic        stretched;
      finished = 1'b0;
      if (phase == IdlePhase) begin
        if (t.cmd_valid) begin
          cmd_kind    = t.kind;
          nak_pending = t.last_read;
          shift_reg   = (t.kind == i2cm_pkg::KindWrite) ? t.tx_byte : 8'h00;
          launch_step(0, t.sda);
        end
      end else if (wait_count != 0) begin
        wait_count = wait_count - 16'd1;
      end else begin
        // hold while the slave stretches SCL after a release
        stretched = (seq_op[cmd_kind][phase - 1] == i2cm_pkg::OpSclHi) && !t.scl;
        if (!stretched) begin
          if (phase >= seq_len[cmd_kind]) begin
            phase    = IdlePhase;
            finished = 1'b1;
            if (cmd_kind == i2cm_pkg::KindRead) begin
              rx_hold = shift_reg;
            end
          end else begin
            launch_step(phase, t.sda);
          end
        end
      end
      r.scl_out = scl_level;
      r.sda_out = sda_level;
      r.ready   = (phase == IdlePhase);
      r.done    = finished;
      r.rx_byte = rx_hold;
      r.ack     = ack_flag;
      expected_lines.push_back(r);
    endfunction

    function void check_lines(line_res_t got);
      line_res_t want;
      if (expected_lines.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportMax) begin
          $display("unexpected line item: scl %b sda %b ready %b done %b rx %h ack %b",
                   got.scl_out, got.sda_out, got.ready, got.done, got.rx_byte, got.ack);
        end
        return;
      end
      want = expected_lines.pop_front();
      if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
          got.ready !== want.ready || got.done !== want.done ||
          got.rx_byte !== want.rx_byte || got.ack !== want.ack) begin
        mismatch_count++;
        if (mismatch_count <= ReportMax) begin
          $display("line mismatch at %0t: exp scl %b sda %b ready %b done %b rx %h ack %b",
                   $time, want.scl_out, want.sda_out, want.ready, want.done,
                   want.rx_byte, want.ack);
          $display("                      got scl %b sda %b ready %b done %b rx %h ack %b",
                   got.scl_out, got.sda_out, got.ready, got.done, got.rx_byte, got.ack);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  line_scoreboard sb;
  bit             tx_bursty;
  bit             rx_bursty;
  int unsigned    rx_hold_req;
  int unsigned    cycle_count;

  i2c_master_byte_engine_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic sda_for(sda_mode_e mode);
    case (mode)
      SdaLow:  return 1'b0;
      SdaHigh: return 1'b1;
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int unsigned hold;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req != 0) begin
        hold        = rx_hold_req;
        rx_hold_req = 0;
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end else if (rx_bursty && $urandom_range(0, 9) < 3) begin
        m_axis_tready <= 1'b0;
        repeat (pick_gap()) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    line_res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.scl_out = m_axis_tdata[0];
      got.sda_out = m_axis_tdata[1];
      got.rx_byte = m_axis_tdata[9:2];
      got.ack     = m_axis_tdata[10];
      got.ready   = m_axis_tuser;
      got.done    = m_axis_tlast;
      sb.check_lines(got);
    end
  end

  // Offer one tick, optionally after a gap; return at the edge that takes it.
  task automatic send_tick(input tick_t t);
    if (tx_bursty && $urandom_range(0, 9) < 3) begin
      s_axis_tvalid <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, t.scl, t.sda, t.tx_byte};
    s_axis_tuser  <= {t.kind, t.cmd_valid};
    s_axis_tlast  <= t.last_read;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.accept_tick(t);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Finish any command in flight, drain, then write the per-step delay.
  task automatic write_delay(input logic [15:0] value);
    tick_t t;
    t = '{cmd_valid: 1'b0, kind: i2cm_pkg::KindStart, tx_byte: 8'h00, last_read: 1'b0,
          sda: 1'b1, scl: 1'b1};
    while (sb.busy()) send_tick(t);
    drain_results();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.delay_ticks = value;
  endtask

  // Issue one command and feed ticks until it reports done.
  task automatic run_command(input logic [1:0] kind, input logic [7:0] tx,
                             input logic last, input sda_mode_e mode,
                             input int unsigned low_ticks, input bit busy_noise);
    tick_t       t;
    int unsigned n;
    t = '{cmd_valid: 1'b1, kind: kind, tx_byte: tx, last_read: last,
          sda: sda_for(mode), scl: 1'b1};
    send_tick(t);
    n = 0;
    while (sb.busy()) begin
      // commands offered here are dropped by the engine
      t.cmd_valid = busy_noise ? 1'($urandom_range(0, 1)) : 1'b0;
      t.kind      = 2'($urandom_range(0, 3));
      t.tx_byte   = 8'($urandom_range(0, 255));
      t.last_read = 1'($urandom_range(0, 1));
      t.sda       = sda_for(mode);
      t.scl       = (n < low_ticks) ? 1'b0 : 1'b1;
      send_tick(t);
      n++;
    end
  endtask

  task automatic random_ticks(input int unsigned count, input bit squeeze);
    tick_t t;
    for (int unsigned i = 0; i < count; i++) begin
      if (squeeze && i == count / 3) begin
        rx_hold_req = 120;
      end
      if (squeeze && i == (2 * count) / 3) begin
        drain_results();
      end
      t.cmd_valid = sb.busy() ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 9) < 7);
      t.kind      = 2'($urandom_range(0, 3));
      t.tx_byte   = 8'($urandom_range(0, 255));
      t.last_read = 1'($urandom_range(0, 1));
      t.sda       = 1'($urandom_range(0, 1));
      t.scl       = ($urandom_range(0, 99) < 85);
      send_tick(t);
    end
  endtask

  initial begin
    sb            = new();
    tx_bursty     = 1'b1;
    rx_bursty     = 1'b1;
    rx_hold_req   = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_delay(16'd0);
    run_command(i2cm_pkg::KindStart, 8'hFF, 1'b1, SdaRand, 0, 1'b0);
    run_command(i2cm_pkg::KindWrite, 8'h00, 1'b1, SdaLow, 0, 1'b0);
    run_command(i2cm_pkg::KindWrite, 8'hFF, 1'b0, SdaHigh, 0, 1'b0);
    // slave holds SCL low for a long time
    run_command(i2cm_pkg::KindWrite, 8'hA5, 1'b0, SdaRand, 40, 1'b0);
    run_command(i2cm_pkg::KindRead, 8'hFF, 1'b0, SdaHigh, 0, 1'b0);
    run_command(i2cm_pkg::KindRead, 8'h00, 1'b1, SdaLow, 0, 1'b0);
    run_command(i2cm_pkg::KindRead, 8'h3C, 1'b0, SdaRand, 3, 1'b1);
    run_command(i2cm_pkg::KindWrite, 8'h5A, 1'b1, SdaRand, 0, 1'b1);
    run_command(i2cm_pkg::KindRead, 8'hC3, 1'b1, SdaRand, 0, 1'b1);
    run_command(i2cm_pkg::KindStop, 8'h00, 1'b0, SdaRand, 2, 1'b1);

    // longer hold, fed back to back
    write_delay(16'd40);
    tx_bursty = 1'b0;
    rx_bursty = 1'b0;
    run_command(i2cm_pkg::KindStop, 8'h81, 1'b1, SdaRand, 0, 1'b1);

    write_delay(16'd0);
    random_ticks(150, 1'b0);
    rx_bursty = 1'b1;
    random_ticks(200, 1'b1);

    tx_bursty = 1'b1;
    write_delay(16'd1);
    run_command(i2cm_pkg::KindRead, 8'h00, 1'b1, SdaRand, 5, 1'b1);
    random_ticks(150, 1'b0);

    write_delay(16'($urandom_range(2, 9)));
    random_ticks(150, 1'b0);

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
